### hw/rtl/stpaxis_pkg.sv
// ----------------------------------------------------------------------------
// stpaxis_pkg
// Types and constants shared by the stepper axis move and home core.
// ----------------------------------------------------------------------------
package stpaxis_pkg;

    // operation codes of a request
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_MOVE    = 3'd1;
    localparam logic [2:0] OP_HOME    = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_SET_POS = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_HAS_ENDSTOP   = 3'd0;
    localparam logic [2:0] CFG_MAX_POSITION  = 3'd1;
    localparam logic [2:0] CFG_HOME_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_SETTLE_TICKS  = 3'd3;
    localparam logic [2:0] CFG_BACKOFF_STEPS = 3'd4;

    // configuration reset values
    localparam logic               RST_HAS_ENDSTOP   = 1'b1;
    localparam logic signed [31:0] RST_MAX_POSITION  = 32'sd40000;
    localparam logic signed [15:0] RST_HOME_OFFSET   = 16'sd0;
    localparam logic [7:0]         RST_SETTLE_TICKS  = 8'd10;
    localparam logic [14:0]        RST_BACKOFF_STEPS = 15'd30;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_MOVING  = 4'b0010,
        MODE_SEEK    = 4'b0100,
        MODE_AT_HOME = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic               endstop_hit;
        logic signed [15:0] move_steps;
        logic [15:0]        move_period;
        logic signed [31:0] new_position;
    } in_t;

    typedef struct packed {
        logic               step_pulse;
        logic               step_toward_home;
        logic               busy_res;
        logic               fault;
        logic signed [31:0] position;
    } out_t;

endpackage

### hw/rtl/stepper_axis_move_and_home_core.sv
// ----------------------------------------------------------------------------
// stepper_axis_move_and_home_core
// One stepper axis: tick, move, home, stop and set position requests.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A request is held in an input
// register while the axis logic (a 32 bit compare and a 32 bit increment or
// decrement) updates the state and loads the result register; one request
// is taken every cycle when the result side keeps up. Configuration writes
// take effect at once and must only be issued while the axis is idle with no
// request in flight.
module stepper_axis_move_and_home_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stpaxis_pkg::in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stpaxis_pkg::out_t   m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import stpaxis_pkg::*;

    // configuration
    logic               has_endstop_reg;
    logic signed [31:0] max_position_reg;
    logic signed [15:0] home_offset_reg;
    logic [7:0]         settle_ticks_reg;
    logic [14:0]        backoff_steps_reg;

    // handshake
    logic in_valid_reg;
    in_t  in_reg;
    logic m_valid_reg;
    out_t out_reg;
    logic advance;

    // axis state
    mode_t              mode_reg, mode_next;
    logic signed [15:0] steps_left_reg, steps_left_next;
    logic [15:0]        step_period_reg, step_period_next;
    logic [15:0]        tick_count_reg, tick_count_next;
    logic [7:0]         settle_count_reg, settle_count_next;
    logic               homing_backoff_reg, homing_backoff_next;
    logic               fault_reg, fault_next;
    logic signed [31:0] position_reg, position_next;
    logic               pulse, toward_home;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_endstop_reg   <= RST_HAS_ENDSTOP;
            max_position_reg  <= RST_MAX_POSITION;
            home_offset_reg   <= RST_HOME_OFFSET;
            settle_ticks_reg  <= RST_SETTLE_TICKS;
            backoff_steps_reg <= RST_BACKOFF_STEPS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HAS_ENDSTOP:   has_endstop_reg   <= cfg_data[0];
                CFG_MAX_POSITION:  max_position_reg  <= cfg_data;
                CFG_HOME_OFFSET:   home_offset_reg   <= cfg_data[15:0];
                CFG_SETTLE_TICKS:  settle_ticks_reg  <= cfg_data[7:0];
                CFG_BACKOFF_STEPS: backoff_steps_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // axis logic: first the operation of the request, then on a task run the mode
    // transition and the step decision on the resulting mode
    always_comb begin
        logic neg;
        logic run;
        neg                 = 1'b0;
        run                 = 1'b0;
        mode_next           = mode_reg;
        steps_left_next     = steps_left_reg;
        step_period_next    = step_period_reg;
        tick_count_next     = tick_count_reg;
        settle_count_next   = settle_count_reg;
        homing_backoff_next = homing_backoff_reg;
        fault_next          = fault_reg;
        position_next       = position_reg;
        pulse               = 1'b0;
        toward_home         = 1'b0;

        case (in_reg.operation)
            OP_TICK: begin
                if (tick_count_reg >= step_period_reg) begin
                    run             = 1'b1;
                    tick_count_next = 16'd1;
                end else if (tick_count_reg != 16'hFFFF) begin
                    tick_count_next = tick_count_reg + 16'd1;
                end
            end
            OP_MOVE: begin
                mode_next           = MODE_MOVING;
                steps_left_next     = in_reg.move_steps;
                step_period_next    = in_reg.move_period;
                tick_count_next     = in_reg.move_period;
                homing_backoff_next = 1'b0;
            end
            OP_HOME: begin
                if (has_endstop_reg) begin
                    mode_next           = MODE_SEEK;
                    homing_backoff_next = 1'b0;
                end
            end
            OP_STOP: begin
                steps_left_next     = 16'sd0;
                mode_next           = MODE_IDLE;
                homing_backoff_next = 1'b0;
            end
            OP_SET_POS: begin
                position_next = in_reg.new_position;
            end
            default: ;
        endcase

        if (run) begin
            case (mode_reg)
                MODE_MOVING: begin
                    if (steps_left_reg == 16'sd0) begin
                        mode_next = MODE_IDLE;
                        if (homing_backoff_reg) begin
                            position_next = 32'sd0 -
                                {{16{home_offset_reg[15]}}, home_offset_reg};
                            homing_backoff_next = 1'b0;
                        end
                    end
                end
                MODE_SEEK: begin
                    step_period_next = 16'd1;
                    if (in_reg.endstop_hit) begin
                        settle_count_next = settle_ticks_reg;
                        mode_next         = MODE_AT_HOME;
                    end
                end
                MODE_AT_HOME: begin
                    if (settle_count_reg != 8'd0) begin
                        settle_count_next = settle_count_reg - 8'd1;
                    end else if (!in_reg.endstop_hit) begin
                        mode_next           = MODE_MOVING;
                        steps_left_next     = {1'b0, backoff_steps_reg};
                        step_period_next    = 16'd1;
                        homing_backoff_next = 1'b1;
                    end
                end
                default: ;
            endcase

            case (mode_next)
                MODE_MOVING: begin
                    if (steps_left_next != 16'sd0) begin
                        neg = steps_left_next[15];
                        if (has_endstop_reg && ((neg && in_reg.endstop_hit) ||
                                (!neg && position_next > max_position_reg))) begin
                            // limit fault abandons the move and any homing
                            fault_next          = 1'b1;
                            mode_next           = MODE_IDLE;
                            steps_left_next     = 16'sd0;
                            homing_backoff_next = 1'b0;
                        end else begin
                            pulse       = 1'b1;
                            toward_home = neg;
                            if (neg) begin
                                if (position_next != POS_MIN) begin
                                    position_next = position_next - 32'sd1;
                                end
                                steps_left_next = steps_left_next + 16'sd1;
                            end else begin
                                if (position_next != POS_MAX) begin
                                    position_next = position_next + 32'sd1;
                                end
                                steps_left_next = steps_left_next - 16'sd1;
                            end
                        end
                    end
                end
                MODE_SEEK: begin
                    pulse       = 1'b1;
                    toward_home = 1'b1;
                end
                MODE_AT_HOME: begin
                    // step off the switch once settled, position unchanged
                    if (settle_count_next == 8'd0) begin
                        pulse = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            mode_reg           <= MODE_IDLE;
            steps_left_reg     <= 16'sd0;
            step_period_reg    <= 16'd1;
            tick_count_reg     <= 16'd0;
            settle_count_reg   <= 8'd0;
            homing_backoff_reg <= 1'b0;
            fault_reg          <= 1'b0;
            position_reg       <= 32'sd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg        <= 1'b1;
                mode_reg           <= mode_next;
                steps_left_reg     <= steps_left_next;
                step_period_reg    <= step_period_next;
                tick_count_reg     <= tick_count_next;
                settle_count_reg   <= settle_count_next;
                homing_backoff_reg <= homing_backoff_next;
                fault_reg          <= fault_next;
                position_reg       <= position_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.step_pulse       <= pulse;
            out_reg.step_toward_home <= toward_home;
            out_reg.busy_res         <= (mode_next != MODE_IDLE);
            out_reg.fault            <= fault_next;
            out_reg.position         <= position_next;
        end
    end

    // fault is sticky until reset
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg |=> fault_reg)
        else $error("fault flag cleared without reset");

    // no direction without a step
    a_dir_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.step_pulse) |-> !m_data.step_toward_home)
        else $error("step direction set without a step");

    // input side only stalls behind a held request and a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a blocked result");

    // a request that advances always produces a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced request gave no result");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper axis move and home core.
// ----------------------------------------------------------------------------
// A clocked driver offers requests from a queue. Each accepted request is run
// through a behavioural copy of the axis, and the result it gives is queued.
// A clocked monitor compares every result field by field with the oldest
// queued result. The run goes through several register settings, each one a
// short burst of homing cycles, moves, position loads and random requests,
// with random gaps on both sides in all but one setting and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb;
    import stpaxis_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 270;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    stepper_axis_move_and_home_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // register copies
    logic               cf_endstop;
    logic signed [31:0] cf_max_pos;
    logic signed [15:0] cf_home_off;
    logic [7:0]         cf_settle;
    logic [14:0]        cf_backoff;

    // axis state
    mode_t              ax_mode;
    logic signed [15:0] ax_steps;
    logic [15:0]        ax_period;
    logic [15:0]        ax_ticks;
    logic [7:0]         ax_settle;
    logic               ax_backoff;
    logic               ax_fault;
    logic signed [31:0] ax_pos;

    in_t  request_q[$];
    out_t axis_results_q[$];
    out_t want;
    int   queued = 0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   idle_pct = 35;
    int   stall_left = 0;
    bit   stall_done = 1'b0;
    int   cycles = 0;

    // one run of the axis task, with the endstop level of this tick
    function automatic void run_axis_task(input logic es, output logic pulse,
                                          output logic dir);
        logic neg;
        pulse = 1'b0;
        dir = 1'b0;
        case (ax_mode)
            MODE_MOVING: begin
                if (ax_steps == 0) begin
                    ax_mode = MODE_IDLE;
                    if (ax_backoff) begin
                        ax_pos = 32'sd0 - {{16{cf_home_off[15]}}, cf_home_off};
                        ax_backoff = 1'b0;
                    end
                end
            end
            MODE_SEEK: begin
                ax_period = 16'd1;
                if (es) begin
                    ax_settle = cf_settle;
                    ax_mode = MODE_AT_HOME;
                end
            end
            MODE_AT_HOME: begin
                if (ax_settle != 0) begin
                    ax_settle = ax_settle - 8'd1;
                end else if (!es) begin
                    ax_mode = MODE_MOVING;
                    ax_steps = {1'b0, cf_backoff};
                    ax_period = 16'd1;
                    ax_backoff = 1'b1;
                end
            end
            default: ;
        endcase
        case (ax_mode)
            MODE_MOVING: begin
                if (ax_steps != 0) begin
                    neg = ax_steps[15];
                    if (cf_endstop && ((neg && es) || (!neg && ax_pos > cf_max_pos))) begin
                        ax_fault = 1'b1;
                        ax_mode = MODE_IDLE;
                        ax_steps = '0;
                        ax_backoff = 1'b0;
                        return;
                    end
                    pulse = 1'b1;
                    dir = neg;
                    if (neg) begin
                        if (ax_pos != POS_MIN) ax_pos = ax_pos - 32'sd1;
                        ax_steps = ax_steps + 16'sd1;
                    end else begin
                        if (ax_pos != POS_MAX) ax_pos = ax_pos + 32'sd1;
                        ax_steps = ax_steps - 16'sd1;
                    end
                end
            end
            MODE_SEEK: begin
                pulse = 1'b1;
                dir = 1'b1;
            end
            MODE_AT_HOME: begin
                if (ax_settle == 0) begin
                    pulse = 1'b1;
                    dir = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic out_t advance_axis(input in_t req);
        out_t res;
        logic pulse, dir;
        pulse = 1'b0;
        dir = 1'b0;
        case (req.operation)
            OP_TICK: begin
                if (ax_ticks >= ax_period) begin
                    run_axis_task(req.endstop_hit, pulse, dir);
                    ax_ticks = '0;
                end
                if (ax_ticks != 16'hFFFF) ax_ticks = ax_ticks + 16'd1;
            end
            OP_MOVE: begin
                ax_mode = MODE_MOVING;
                ax_steps = req.move_steps;
                ax_period = req.move_period;
                ax_ticks = req.move_period;
                ax_backoff = 1'b0;
            end
            OP_HOME: begin
                if (cf_endstop) begin
                    ax_mode = MODE_SEEK;
                    ax_backoff = 1'b0;
                end
            end
            OP_STOP: begin
                ax_steps = '0;
                ax_mode = MODE_IDLE;
                ax_backoff = 1'b0;
            end
            OP_SET_POS: ax_pos = req.new_position;
            default: ;
        endcase
        res.step_pulse = pulse;
        res.step_toward_home = pulse & dir;
        res.busy_res = (ax_mode != MODE_IDLE);
        res.fault = ax_fault;
        res.position = ax_pos;
        return res;
    endfunction

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) axis_results_q.push_back(advance_axis(s_data));
            if (!s_valid || s_ready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= request_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string fname, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, fname, exp_v, got_v);
        end
    endtask

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (axis_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result %h", $time, m_data);
                end else begin
                    want = axis_results_q.pop_front();
                    report_field("step_pulse", want.step_pulse, m_data.step_pulse);
                    report_field("step_toward_home", want.step_toward_home,
                                 m_data.step_toward_home);
                    report_field("busy_res", want.busy_res, m_data.busy_res);
                    report_field("fault", want.fault, m_data.fault);
                    report_field("position", want.position, m_data.position);
                end
            end
            // one long hold-off so that the core backs up and stalls its input
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (results_seen == 1100 && !stall_done) begin
                stall_done = 1'b1;
                stall_left = 300;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HAS_ENDSTOP:   cf_endstop = val[0];
            CFG_MAX_POSITION:  cf_max_pos = val;
            CFG_HOME_OFFSET:   cf_home_off = val[15:0];
            CFG_SETTLE_TICKS:  cf_settle = val[7:0];
            CFG_BACKOFF_STEPS: cf_backoff = val[14:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] es, input logic [31:0] mx,
                                input logic [31:0] ho, input logic [31:0] st,
                                input logic [31:0] bo);
        write_reg(CFG_HAS_ENDSTOP, es);
        write_reg(CFG_MAX_POSITION, mx);
        write_reg(CFG_HOME_OFFSET, ho);
        write_reg(CFG_SETTLE_TICKS, st);
        write_reg(CFG_BACKOFF_STEPS, bo);
    endtask

    // wait until every request has been taken and every result checked
    task automatic drain();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_valid || axis_results_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_item(input logic [2:0] op, input logic es,
                             input logic [15:0] st, input logic [15:0] per,
                             input logic [31:0] np);
        in_t req;
        req.operation = op;
        req.endstop_hit = es;
        req.move_steps = st;
        req.move_period = per;
        req.new_position = np;
        request_q.push_back(req);
        queued++;
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 4))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return cf_max_pos + 32'($urandom_range(0, 6)) - 32'd3;
            3: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int n);
        int goal, kind, s, h, r, cut, k, mag, len;
        logic [15:0] st, per;
        goal = queued + n;
        while (queued < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                // homing: seek, sit on the switch through settle, release, back off
                push_item(OP_MOVE, $urandom, 16'd0, 16'($urandom_range(0, 2)), $urandom);
                push_item(OP_HOME, $urandom, $urandom, $urandom, $urandom);
                s = $urandom_range(0, 3);
                h = int'(cf_settle) + $urandom_range(1, 3);
                r = ((cf_backoff > 40) ? 40 : int'(cf_backoff)) + $urandom_range(1, 3);
                cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, s + h + r - 1)
                                                   : s + h + r;
                for (k = 0; k < s + h + r; k++) begin
                    if (k == cut) begin
                        if ($urandom_range(0, 1) == 0)
                            push_item(OP_STOP, $urandom, $urandom, $urandom, $urandom);
                        else
                            push_item(OP_MOVE, $urandom, 16'($urandom_range(0, 10)) - 16'd5,
                                      16'($urandom_range(0, 2)), $urandom);
                        break;
                    end
                    push_item(OP_TICK, (k >= s && k < s + h), $urandom, $urandom, $urandom);
                end
            end else if (kind < 60) begin
                st = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 40)) - 16'd20;
                per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
                mag = st[15] ? -int'($signed(st)) : int'(st);
                if (mag > 60 || per > 60) len = 60;
                else len = (mag + 1) * (int'(per) + 1) + 1;
                if (len > 60) len = 60;
                cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, len - 1) : len;
                push_item(OP_MOVE, $urandom, st, per, $urandom);
                for (k = 0; k < len; k++) begin
                    if (k == cut) begin
                        push_item(OP_STOP, $urandom, $urandom, $urandom, $urandom);
                        break;
                    end
                    push_item(OP_TICK, ($urandom_range(0, 99) < 5), $urandom, $urandom,
                              $urandom);
                end
            end else if (kind < 70) begin
                push_item(OP_SET_POS, $urandom, $urandom, $urandom, pick_position());
            end else begin
                push_item(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        cf_endstop = RST_HAS_ENDSTOP;
        cf_max_pos = RST_MAX_POSITION;
        cf_home_off = RST_HOME_OFFSET;
        cf_settle = RST_SETTLE_TICKS;
        cf_backoff = RST_BACKOFF_STEPS;
        ax_mode = MODE_IDLE;
        ax_steps = '0;
        ax_period = 16'd1;
        ax_ticks = '0;
        ax_settle = '0;
        ax_backoff = 1'b0;
        ax_fault = 1'b0;
        ax_pos = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: no settle, no back-off, most negative home offset
        apply_config(32'd1, 32'sd40000, 32'hFFFF_8000, 32'd0, 32'd0);
        push_item(3'd5, $urandom, $urandom, $urandom, $urandom);
        push_item(3'd6, $urandom, $urandom, $urandom, $urandom);
        push_item(3'd7, $urandom, $urandom, $urandom, $urandom);
        // stepping down from the lowest position, zero period
        push_item(OP_SET_POS, 1'b0, '0, '0, POS_MIN);
        push_item(OP_MOVE, 1'b0, -16'sd2, 16'd0, '0);
        repeat (3) push_item(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
        // full homing with an immediate release and no back-off
        push_item(OP_HOME, 1'b0, $urandom, $urandom, $urandom);
        push_item(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
        push_item(OP_TICK, 1'b1, $urandom, $urandom, $urandom);
        push_item(OP_TICK, 1'b1, $urandom, $urandom, $urandom);
        push_item(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
        push_item(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
        // switch pressed on a move toward home
        push_item(OP_MOVE, 1'b0, -16'sd5, 16'd1, '0);
        push_item(OP_TICK, 1'b1, $urandom, $urandom, $urandom);
        push_item(OP_MOVE, 1'b0, 16'sh7FFF, 16'hFFFF, '0);
        push_item(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
        push_item(OP_MOVE, 1'b1, 16'sh8000, 16'd1, '0);
        push_item(OP_STOP, 1'b0, $urandom, $urandom, $urandom);
        // past the limit on a move away from home
        push_item(OP_SET_POS, 1'b0, '0, '0, POS_MAX);
        push_item(OP_MOVE, 1'b0, 16'sd1, 16'd0, '0);
        push_item(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
        drain();

        apply_config(32'd1, 32'sd40000, 32'd0, 32'd10, 32'd30);
        queue_random(PHASE_ITEMS);
        drain();

        apply_config(32'd0, POS_MIN, 32'h0000_7FFF, 32'd255, 32'h0000_7FFF);
        queue_random(PHASE_ITEMS);
        drain();

        // no gaps on either side here
        idle_pct = 0;
        apply_config(32'd1, POS_MAX, 32'hFFFF_FFFF, 32'd0, 32'd1);
        queue_random(PHASE_ITEMS);
        drain();
        idle_pct = 35;

        apply_config(32'd1, -32'sd100, 32'd123, 32'd3, 32'd5);
        queue_random(PHASE_ITEMS);
        drain();

        apply_config(32'd1, 32'sd1000, 32'hFFFF_8000, 32'd255, 32'd2);
        queue_random(PHASE_ITEMS);
        drain();

        apply_config(32'd1, 32'sd0, 32'd100, 32'd1, 32'd0);
        queue_random(PHASE_ITEMS);
        drain();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && axis_results_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/stpaxis_pkg.sv
hw/rtl/stepper_axis_move_and_home_core.sv
test/tb.sv
